[hdl/ssf_pkg.sv]
// ----------------------------------------------------------------------------
// ssf_pkg
// Shared types, constants and helpers for the stencil smoothing filter.
// ----------------------------------------------------------------------------
package ssf_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int MAX_PASSES  = 7;

    localparam int DATA_W    = 32;
    localparam int SAT_W     = (VALUE_WIDTH < DATA_W) ? VALUE_WIDTH : DATA_W;
    localparam int WORK_W    = DATA_W + 4;
    localparam int PASS_W    = 3;
    localparam int CFG_W     = 3;
    localparam int CFG_IDX_W = 3;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CFG_IDX_W-1:0] CFG_TWO_DIMENSIONAL = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_WET_DRY_MODE    = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_OUTER_PASSES    = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_INNER_PASSES    = CFG_IDX_W'(3);

    typedef logic signed [DATA_W-1:0] value_t;
    typedef logic signed [WORK_W-1:0] work_t;

    localparam work_t SAT_HI = WORK_W'((64'sd1 <<< (SAT_W - 1)) - 64'sd1);
    localparam work_t SAT_LO = -SAT_HI - WORK_W'(1);

    typedef struct packed {
        logic                  two_d;
        logic                  wet_dry;
        logic [PASS_W-1:0]     outer;
        logic [PASS_W-1:0]     inner;
    } cfg_t;

    // One classified cell, as handed from the front end to the sequencer
    typedef struct packed {
        value_t                center;
        value_t                south;
        value_t                north;
        value_t                east;
        value_t                west;
        logic                  mir_s;
        logic                  mir_n;
        logic                  mir_e;
        logic                  mir_w;
        logic                  two_d;
        logic                  bypass;
        logic                  dry;
        logic [PASS_W-1:0]     outer;
        logic [PASS_W-1:0]     inner;
    } item_t;

    typedef struct packed {
        logic                  running;
        logic                  correcting;
        logic [PASS_W-1:0]     outer_left;
        logic [PASS_W-1:0]     inner_left;
    } back_status_t;

    function automatic value_t saturate(input work_t v);
        value_t r;
        if (v > SAT_HI)
        begin
            r = value_t'(SAT_HI);
        end
        else if (v < SAT_LO)
        begin
            r = value_t'(SAT_LO);
        end
        else
        begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction

    function automatic logic [PASS_W-1:0] limit_passes(input logic [PASS_W-1:0] n);
        logic [PASS_W-1:0] r;
        if (int'(n) > MAX_PASSES)
        begin
            r = PASS_W'(MAX_PASSES);
        end
        else
        begin
            r = n;
        end
        return r;
    endfunction

endpackage

[hdl/ssf_front.sv]
// ----------------------------------------------------------------------------
// ssf_front
// Accepts a cell transaction and classifies it: mirror flags, 1D masking,
// pass limits and pass-through detection.
// ----------------------------------------------------------------------------
module ssf_front (
    input  logic           start,
    input  logic           busy,
    input  ssf_pkg::cfg_t  cfg,
    input  ssf_pkg::value_t center_value,
    input  ssf_pkg::value_t south_value,
    input  ssf_pkg::value_t north_value,
    input  ssf_pkg::value_t east_value,
    input  ssf_pkg::value_t west_value,
    input  logic           center_wet,
    input  logic           south_wet,
    input  logic           north_wet,
    input  logic           east_wet,
    input  logic           west_wet,
    output logic           push,
    output ssf_pkg::item_t push_item
);
    import ssf_pkg::*;

    logic              wd;
    logic              d2;
    logic [PASS_W-1:0] outer_lim;

    assign wd        = cfg.wet_dry;
    assign d2        = cfg.two_d;
    assign outer_lim = limit_passes(cfg.outer);
    assign push      = start && !busy;

    always_comb
    begin
        push_item.center = center_value;
        push_item.south  = south_value;
        push_item.north  = north_value;
        // in 1D the east/west terms drop out of every sum
        push_item.east   = d2 ? east_value : '0;
        push_item.west   = d2 ? west_value : '0;
        push_item.mir_s  = wd && !south_wet;
        push_item.mir_n  = wd && !north_wet;
        push_item.mir_e  = d2 && wd && !east_wet;
        push_item.mir_w  = d2 && wd && !west_wet;
        push_item.two_d  = d2;
        push_item.dry    = wd && !center_wet;
        push_item.bypass = (wd && !center_wet) || (outer_lim == '0);
        push_item.outer  = outer_lim;
        push_item.inner  = limit_passes(cfg.inner);
    end

endmodule

[hdl/ssf_queue.sv]
// ----------------------------------------------------------------------------
// ssf_queue
// Short FIFO between the front end and the pass sequencer.
// ----------------------------------------------------------------------------
module ssf_queue (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  ssf_pkg::item_t             push_item,
    input  logic                       pop,
    output ssf_pkg::item_t             head_item,
    output logic                       not_empty,
    output logic                       full,
    output logic [ssf_pkg::QCNT_W-1:0] count
);
    import ssf_pkg::*;

    item_t             mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    function automatic logic [QPTR_W-1:0] bump(input logic [QPTR_W-1:0] p);
        logic [QPTR_W-1:0] r;
        if (p == QPTR_W'(QUEUE_DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + QPTR_W'(1);
        end
        return r;
    endfunction

    assign head_item = mem[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign count     = count_reg;

    always_comb
    begin
        wr_ptr_next = push ? bump(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop  ? bump(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

[hdl/ssf_back.sv]
// ----------------------------------------------------------------------------
// ssf_back
// Pass sequencer: one predictor or one corrector step per cycle, then a one-cycle
// result strobe.
// ----------------------------------------------------------------------------
module ssf_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_valid,
    input  ssf_pkg::item_t        q_item,
    output logic                  q_pop,
    output logic                  done,
    output ssf_pkg::value_t       filtered_value,
    output ssf_pkg::back_status_t status
);
    import ssf_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_PRED = 2'd1;
    localparam logic [1:0] ST_CORR = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [PASS_W-1:0] outer_left_reg, outer_left_next;
    logic [PASS_W-1:0] inner_left_reg, inner_left_next;
    logic              done_reg, done_next;
    value_t            result_reg, result_next;
    value_t            hp_reg, hp_next;
    value_t            f_reg, f_next;
    item_t             item_reg, item_next;

    work_t             pred_sum;
    work_t             pred_raw;
    value_t            pred_val;
    work_t             d0;
    work_t             ds;
    work_t             corr_raw;
    value_t            corr_val;
    logic [2:0]        mcount;
    logic              finish;
    value_t            fin_val;
    logic              take;

    // predictor: hp is the current value
    always_comb
    begin
        pred_sum = WORK_W'(item_reg.mir_s ? f_reg : item_reg.south)
                 + WORK_W'(item_reg.mir_n ? f_reg : item_reg.north)
                 + WORK_W'(item_reg.mir_e ? f_reg : item_reg.east)
                 + WORK_W'(item_reg.mir_w ? f_reg : item_reg.west);
        pred_raw = (WORK_W'(f_reg) >>> 1)
                 + (item_reg.two_d ? (pred_sum >>> 3) : (pred_sum >>> 2));
        pred_val = saturate(pred_raw);
    end

    // corrector: mirrored neighbours each contribute d0
    always_comb
    begin
        d0     = WORK_W'(hp_reg) - WORK_W'(f_reg);
        mcount = {2'b00, item_reg.mir_s} + {2'b00, item_reg.mir_n}
               + {2'b00, item_reg.mir_e} + {2'b00, item_reg.mir_w};
        unique case (mcount)
            3'd0:    ds = '0;
            3'd1:    ds = d0;
            3'd2:    ds = d0 <<< 1;
            3'd3:    ds = (d0 <<< 1) + d0;
            3'd4:    ds = d0 <<< 2;
            default: ds = '0;
        endcase
        corr_raw = WORK_W'(f_reg) + (d0 >>> 1)
                 + (item_reg.two_d ? (ds >>> 3) : (ds >>> 2));
        corr_val = saturate(corr_raw);
    end

    always_comb
    begin
        state_next      = state_reg;
        outer_left_next = outer_left_reg;
        inner_left_next = inner_left_reg;
        done_next       = 1'b0;
        result_next     = result_reg;
        hp_next         = hp_reg;
        f_next          = f_reg;
        item_next       = item_reg;
        finish          = 1'b0;
        fin_val         = pred_val;
        q_pop           = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                state_next = ST_IDLE;
            end
            ST_PRED:
            begin
                hp_next = f_reg;
                f_next  = pred_val;
                if (item_reg.inner == '0)
                begin
                    outer_left_next = outer_left_reg - PASS_W'(1);
                    if (outer_left_reg == PASS_W'(1))
                    begin
                        finish  = 1'b1;
                        fin_val = pred_val;
                    end
                end
                else
                begin
                    inner_left_next = item_reg.inner;
                    state_next      = ST_CORR;
                end
            end
            ST_CORR:
            begin
                f_next          = corr_val;
                inner_left_next = inner_left_reg - PASS_W'(1);
                if (inner_left_reg == PASS_W'(1))
                begin
                    outer_left_next = outer_left_reg - PASS_W'(1);
                    if (outer_left_reg == PASS_W'(1))
                    begin
                        finish  = 1'b1;
                        fin_val = corr_val;
                    end
                    else
                    begin
                        state_next = ST_PRED;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (finish)
        begin
            done_next   = 1'b1;
            result_next = fin_val;
            state_next  = ST_IDLE;
        end

        // next cell loads on the finishing cycle unless it needs its own strobe
        take = q_valid && ((state_reg == ST_IDLE) || (finish && !q_item.bypass));
        if (take)
        begin
            q_pop = 1'b1;
            if (q_item.bypass)
            begin
                done_next   = 1'b1;
                result_next = q_item.dry ? q_item.center
                                         : saturate(WORK_W'(q_item.center));
                state_next  = ST_IDLE;
            end
            else
            begin
                item_next       = q_item;
                f_next          = saturate(WORK_W'(q_item.center));
                outer_left_next = q_item.outer;
                state_next      = ST_PRED;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        hp_reg     <= hp_next;
        f_reg      <= f_next;
        item_reg   <= item_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            outer_left_reg <= '0;
            inner_left_reg <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            outer_left_reg <= outer_left_next;
            inner_left_reg <= inner_left_next;
            done_reg       <= done_next;
        end
    end

    assign done           = done_reg;
    assign filtered_value = result_reg;

    always_comb
    begin
        status.running    = (state_reg != ST_IDLE);
        status.correcting = (state_reg == ST_CORR);
        status.outer_left = outer_left_reg;
        status.inner_left = inner_left_reg;
    end

endmodule

[hdl/stencil_smoothing_filter_unit.sv]
// ----------------------------------------------------------------------------
// stencil_smoothing_filter_unit
// Five-point predictor/corrector smoothing of one cell, signed Q16.16.
// ----------------------------------------------------------------------------
// The queue hands each accepted cell to the sequencer, which runs outer predictor
//   passes, each followed by inner corrector steps, and then strobes done.
// The sequencer filters one cell at a time; a dry or zero-pass cell skips the
//   passes and strobes done as soon as the sequencer takes it from the queue.
// A 2-entry queue lets start be taken while the sequencer works; busy = full.
// Reset: config back to 2D, wet-dry off, 1/1 passes; queue empty, no strobe.
module stencil_smoothing_filter_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          cfg_we,
    input  logic [ssf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ssf_pkg::CFG_W-1:0]     cfg_data,
    input  ssf_pkg::value_t               center_value,
    input  ssf_pkg::value_t               south_value,
    input  ssf_pkg::value_t               north_value,
    input  ssf_pkg::value_t               east_value,
    input  ssf_pkg::value_t               west_value,
    input  logic                          center_wet,
    input  logic                          south_wet,
    input  logic                          north_wet,
    input  logic                          east_wet,
    input  logic                          west_wet,
    output logic                          done,
    output ssf_pkg::value_t               filtered_value
);
    import ssf_pkg::*;

    logic              two_dimensional_reg;
    logic              wet_dry_mode_reg;
    logic [PASS_W-1:0] outer_passes_reg;
    logic [PASS_W-1:0] inner_passes_reg;
    cfg_t              cfg;

    logic              push;
    item_t             push_item;
    logic              pop;
    item_t             head_item;
    logic              not_empty;
    logic              full;
    logic [QCNT_W-1:0] q_count;
    back_status_t      status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            two_dimensional_reg <= 1'b1;
            wet_dry_mode_reg    <= 1'b0;
            outer_passes_reg    <= PASS_W'(1);
            inner_passes_reg    <= PASS_W'(1);
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_TWO_DIMENSIONAL)
            begin
                two_dimensional_reg <= cfg_data[0];
            end
            else if (cfg_index == CFG_WET_DRY_MODE)
            begin
                wet_dry_mode_reg <= cfg_data[0];
            end
            else if (cfg_index == CFG_OUTER_PASSES)
            begin
                outer_passes_reg <= cfg_data[PASS_W-1:0];
            end
            else if (cfg_index == CFG_INNER_PASSES)
            begin
                inner_passes_reg <= cfg_data[PASS_W-1:0];
            end
        end
    end

    always_comb
    begin
        cfg.two_d   = two_dimensional_reg;
        cfg.wet_dry = wet_dry_mode_reg;
        cfg.outer   = outer_passes_reg;
        cfg.inner   = inner_passes_reg;
    end

    assign busy = full;

    ssf_front u_front (
        .start        (start),
        .busy         (full),
        .cfg          (cfg),
        .center_value (center_value),
        .south_value  (south_value),
        .north_value  (north_value),
        .east_value   (east_value),
        .west_value   (west_value),
        .center_wet   (center_wet),
        .south_wet    (south_wet),
        .north_wet    (north_wet),
        .east_wet     (east_wet),
        .west_wet     (west_wet),
        .push         (push),
        .push_item    (push_item)
    );

    ssf_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head_item (head_item),
        .not_empty (not_empty),
        .full      (full),
        .count     (q_count)
    );

    ssf_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_valid        (not_empty),
        .q_item         (head_item),
        .q_pop          (pop),
        .done           (done),
        .filtered_value (filtered_value),
        .status         (status)
    );

    // accepted transaction is always queued or still queued behind a pop
    a_accept_queued: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (q_count != '0))
        else $error("accepted transaction not held in queue");

    // a result strobe only follows a running sequencer or a queue pop
    a_done_source: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(status.running || pop))
        else $error("result strobe without work");

    a_outer_live: assert property (@(posedge clk) disable iff (!rst_n)
        status.running |-> (status.outer_left != '0))
        else $error("sequencer running with no passes left");

    a_inner_live: assert property (@(posedge clk) disable iff (!rst_n)
        status.correcting |-> (status.inner_left != '0))
        else $error("corrector running with no steps left");

endmodule

[test/stencil_smoothing_filter_unit_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stencil_smoothing_filter_unit_test
// Self-checking bench for the five-point smoothing filter. Cells go in on the
// start/busy handshake in random bursts. A bit-accurate software version of the
// predictor/corrector computes each expected filtered value when the cell is
// accepted. Every done strobe is checked in order against those values. The
// registers are rewritten between phases, always with the unit idle.
// ----------------------------------------------------------------------------
module stencil_smoothing_filter_unit_test;
    import ssf_pkg::*;

    localparam int RANDOM_CELLS = 1800;
    localparam int REPORT_LIMIT = 10;
    // drain margin sized from the longest cell, MAX_PASSES outer and inner passes
    localparam int DRAIN_CYCLES = MAX_PASSES * (MAX_PASSES + 1) + 16;
    localparam int TIMEOUT_NS   = 2_000_000;

    localparam value_t Q_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam value_t Q_MIN = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_FIRST = CFG_INNER_PASSES + 1'b1;

    typedef enum logic {JOB_CELL, JOB_CFG} job_kind_t;

    typedef struct packed {
        job_kind_t              kind;
        logic [CFG_IDX_W-1:0]   idx;
        logic [CFG_W-1:0]       data;
        value_t                 ctr;
        value_t                 sth;
        value_t                 nth;
        value_t                 est;
        value_t                 wst;
        logic [4:0]             wet;    // center, south, north, east, west
    } job_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   start = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_W-1:0]       cfg_data = '0;
    value_t                 center_value = '0;
    value_t                 south_value = '0;
    value_t                 north_value = '0;
    value_t                 east_value = '0;
    value_t                 west_value = '0;
    logic                   center_wet = 1'b0;
    logic                   south_wet = 1'b0;
    logic                   north_wet = 1'b0;
    logic                   east_wet = 1'b0;
    logic                   west_wet = 1'b0;
    logic                   busy;
    logic                   done;
    value_t                 filtered_value;

    job_t                   pending_jobs[$];
    value_t                 expected_values[$];
    cfg_t                   filter_regs;
    logic                   taken = 1'b0;
    int                     burst_left = 0;
    int                     gap_left = 0;
    int                     cells_queued = 0;
    int                     cells_accepted = 0;
    int                     results_checked = 0;
    int                     dry_passthrough = 0;
    int                     cfg_writes = 0;
    int                     errors = 0;

    stencil_smoothing_filter_unit uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .center_value   (center_value),
        .south_value    (south_value),
        .north_value    (north_value),
        .east_value     (east_value),
        .west_value     (west_value),
        .center_wet     (center_wet),
        .south_wet      (south_wet),
        .north_wet      (north_wet),
        .east_wet       (east_wet),
        .west_wet       (west_wet),
        .done           (done),
        .filtered_value (filtered_value)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    initial
    begin
        #TIMEOUT_NS;
        $display("timeout: %0d of %0d cells accepted", cells_accepted, cells_queued);
        $display("end of test: mismatches");
        $finish;
    end

    function automatic longint clamp_q(longint v);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (SAT_W - 1)) - 1;
        lo = -hi - 1;
        if (v > hi)
        begin
            return hi;
        end
        if (v < lo)
        begin
            return lo;
        end
        return v;
    endfunction

    function automatic value_t smoothed_center(job_t j, cfg_t r);
        longint vc, vs, vn, ve, vw;
        longint hp, f, sum, d0, ds;
        int     k, outer, inner, a, b;
        logic   ms, mn, me, mw;
        vc = longint'(j.ctr);
        vs = longint'(j.sth);
        vn = longint'(j.nth);
        ve = longint'(j.est);
        vw = longint'(j.wst);
        // dry neighbors are mirrored from the center (zero gradient)
        ms = r.wet_dry && !j.wet[3];
        mn = r.wet_dry && !j.wet[2];
        me = r.wet_dry && !j.wet[1];
        mw = r.wet_dry && !j.wet[0];
        k = r.two_d ? 3 : 2;
        outer = (int'(r.outer) > MAX_PASSES) ? MAX_PASSES : int'(r.outer);
        inner = (int'(r.inner) > MAX_PASSES) ? MAX_PASSES : int'(r.inner);
        if (r.wet_dry && !j.wet[4])
        begin
            return j.ctr;
        end
        f = clamp_q(vc);
        for (a = 0; a < outer; a++)
        begin
            hp = f;
            sum = (ms ? hp : vs) + (mn ? hp : vn);
            if (r.two_d)
            begin
                sum += (me ? hp : ve) + (mw ? hp : vw);
            end
            f = clamp_q((hp >>> 1) + (sum >>> k));
            for (b = 0; b < inner; b++)
            begin
                d0 = hp - f;
                ds = (ms ? d0 : 64'sd0) + (mn ? d0 : 64'sd0);
                if (r.two_d)
                begin
                    ds += (me ? d0 : 64'sd0) + (mw ? d0 : 64'sd0);
                end
                f = clamp_q(f + (d0 >>> 1) + (ds >>> k));
            end
        end
        return f[DATA_W-1:0];
    endfunction

    // mostly neighbors close to the center, with full-range and corner values mixed in
    function automatic value_t pick_value(value_t base);
        longint offset;
        case ($urandom_range(0, 9))
            0:
            begin
                case ($urandom_range(0, 4))
                    0: return Q_MAX;
                    1: return Q_MIN;
                    2: return '0;
                    3: return '1;
                    default: return value_t'(1);
                endcase
            end
            1, 2, 3, 4:
            begin
                return value_t'($urandom);
            end
            default:
            begin
                offset = longint'($urandom_range(0, 1 << 19)) - (longint'(1) << 18);
                return value_t'(longint'(base) + offset);
            end
        endcase
    endfunction

    task automatic queue_cfg(logic [CFG_IDX_W-1:0] idx, int unsigned data);
        job_t j;
        j = '0;
        j.kind = JOB_CFG;
        j.idx = idx;
        j.data = CFG_W'(data);
        pending_jobs.push_back(j);
    endtask

    task automatic queue_cell(value_t c, value_t s, value_t n, value_t e, value_t w,
                              logic [4:0] wet);
        job_t j;
        j.kind = JOB_CELL;
        j.idx = '0;
        j.data = '0;
        j.ctr = c;
        j.sth = s;
        j.nth = n;
        j.est = e;
        j.wst = w;
        j.wet = wet;
        pending_jobs.push_back(j);
        cells_queued++;
    endtask

    task automatic log_failure(string what);
        errors++;
        if (errors <= REPORT_LIMIT)
        begin
            $display("ERROR @%0t: %s", $realtime, what);
        end
    endtask

    // driver: cells and register writes change at the falling edge
    always @(negedge clk)
    begin : drive_proc
        job_t j;
        if (rst_n)
        begin
            if (start && !taken)
            begin
                // transaction still pending, hold everything
            end
            else if (gap_left > 0)
            begin
                gap_left--;
                start <= 1'b0;
                cfg_we <= 1'b0;
            end
            else if (pending_jobs.size() == 0)
            begin
                start <= 1'b0;
                cfg_we <= 1'b0;
            end
            else if (pending_jobs[0].kind == JOB_CFG)
            begin
                start <= 1'b0;
                // registers change only with the unit drained
                if (expected_values.size() == 0)
                begin
                    j = pending_jobs.pop_front();
                    cfg_we <= 1'b1;
                    cfg_index <= j.idx;
                    cfg_data <= j.data;
                end
                else
                begin
                    cfg_we <= 1'b0;
                end
            end
            else
            begin
                j = pending_jobs.pop_front();
                start <= 1'b1;
                cfg_we <= 1'b0;
                center_value <= j.ctr;
                south_value <= j.sth;
                north_value <= j.nth;
                east_value <= j.est;
                west_value <= j.wst;
                {center_wet, south_wet, north_wet, east_wet, west_wet} <= j.wet;
                if (burst_left > 0)
                begin
                    burst_left--;
                end
                else
                begin
                    burst_left = $urandom_range(1, 24);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
                end
            end
        end
    end

    // monitor: register writes, accepted cells and results seen at the rising edge
    always @(posedge clk or negedge rst_n)
    begin : watch_proc
        job_t   seen;
        value_t want;
        if (!rst_n)
        begin
            taken <= 1'b0;
            filter_regs = '{two_d: 1'b1, wet_dry: 1'b0, outer: PASS_W'(1), inner: PASS_W'(1)};
        end
        else
        begin
            taken <= start && !busy;
            if (cfg_we)
            begin
                cfg_writes++;
                case (cfg_index)
                    CFG_TWO_DIMENSIONAL: filter_regs.two_d = cfg_data[0];
                    CFG_WET_DRY_MODE:    filter_regs.wet_dry = cfg_data[0];
                    CFG_OUTER_PASSES:    filter_regs.outer = cfg_data[PASS_W-1:0];
                    CFG_INNER_PASSES:    filter_regs.inner = cfg_data[PASS_W-1:0];
                    default: ;
                endcase
            end
            if (done)
            begin
                if (expected_values.size() == 0)
                begin
                    log_failure($sformatf("result %0h with nothing outstanding",
                                          filtered_value));
                end
                else
                begin
                    want = expected_values.pop_front();
                    results_checked++;
                    if (filtered_value !== want)
                    begin
                        log_failure($sformatf("filtered_value expected %0h got %0h",
                                              want, filtered_value));
                    end
                end
            end
            if (start && !busy)
            begin
                seen.kind = JOB_CELL;
                seen.idx = '0;
                seen.data = '0;
                seen.ctr = center_value;
                seen.sth = south_value;
                seen.nth = north_value;
                seen.est = east_value;
                seen.wst = west_value;
                seen.wet = {center_wet, south_wet, north_wet, east_wet, west_wet};
                expected_values.push_back(smoothed_center(seen, filter_regs));
                cells_accepted++;
                if (filter_regs.wet_dry && !center_wet)
                begin
                    dry_passthrough++;
                end
            end
        end
    end

    initial
    begin : stimulus_proc
        value_t c;
        int     phase_cells;
        int     sel;
        int     i;

        // directed: corner values at reset settings
        queue_cell('0, '0, '0, '0, '0, 5'b11111);
        queue_cell(Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, 5'b11111);
        queue_cell(Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, 5'b00000);
        queue_cell(Q_MAX, Q_MIN, Q_MIN, Q_MIN, Q_MIN, 5'b11111);
        queue_cell(Q_MIN, Q_MAX, Q_MAX, Q_MAX, Q_MAX, 5'b11111);
        // 1D, wet-dry on, longest pass counts
        queue_cfg(CFG_TWO_DIMENSIONAL, 0);
        queue_cfg(CFG_WET_DRY_MODE, 7);
        queue_cfg(CFG_OUTER_PASSES, 7);
        queue_cfg(CFG_INNER_PASSES, 7);
        queue_cell(Q_MAX, '0, Q_MIN, Q_MAX, Q_MIN, 5'b01111);
        queue_cell(32'h0003_8000, 32'h0001_0000, 32'hFFFE_0000, Q_MAX, Q_MIN, 5'b10000);
        queue_cell(32'hFFFF_4000, Q_MAX, 32'h0000_0001, Q_MIN, Q_MAX, 5'b11010);
        queue_cell(Q_MIN, Q_MAX, Q_MAX, Q_MIN, Q_MIN, 5'b11111);
        // 2D without correctors, mixed dry neighbors
        queue_cfg(CFG_TWO_DIMENSIONAL, 1);
        queue_cfg(CFG_INNER_PASSES, 0);
        queue_cell(Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX, 5'b10101);
        queue_cell(32'h0000_8000, 32'h0001_0000, '1, 32'h0000_0003, 32'hFFFF_FFFD, 5'b10110);
        // zero predictor passes leave the center alone
        queue_cfg(CFG_OUTER_PASSES, 0);
        queue_cell(Q_MIN, Q_MAX, Q_MAX, Q_MAX, Q_MAX, 5'b11111);
        queue_cell(Q_MAX, Q_MIN, Q_MIN, Q_MIN, Q_MIN, 5'b01001);
        // wet-dry off: flags ignored, everything filtered
        queue_cfg(CFG_OUTER_PASSES, 1);
        queue_cfg(CFG_INNER_PASSES, 1);
        queue_cfg(CFG_WET_DRY_MODE, 0);
        queue_cell(32'h0001_0000, Q_MAX, Q_MIN, 32'h7FFF_0000, 32'h8001_0000, 5'b00000);
        // writes past the last register must not disturb anything
        queue_cfg(CFG_UNUSED_FIRST, 7);
        queue_cfg(CFG_IDX_W'((1 << CFG_IDX_W) - 1), 0);
        queue_cell(32'h1234_5678, 32'h1234_0000, 32'h1235_0000, 32'h1233_0000,
                   32'h1236_0000, 5'b11111);

        // random phases, registers rewritten between them
        while (cells_queued < RANDOM_CELLS + 20)
        begin
            queue_cfg(CFG_TWO_DIMENSIONAL, $urandom_range(0, 7));
            queue_cfg(CFG_WET_DRY_MODE, $urandom_range(0, 7));
            sel = $urandom_range(0, 3);
            queue_cfg(CFG_OUTER_PASSES, (sel == 0) ? 0 : (sel == 1) ? 7 : $urandom_range(0, 7));
            sel = $urandom_range(0, 3);
            queue_cfg(CFG_INNER_PASSES, (sel == 0) ? 0 : (sel == 1) ? 7 : $urandom_range(0, 7));
            if ($urandom_range(0, 4) == 0)
            begin
                queue_cfg(CFG_IDX_W'($urandom_range(int'(CFG_UNUSED_FIRST), (1 << CFG_IDX_W) - 1)),
                          $urandom_range(0, 7));
            end
            phase_cells = $urandom_range(40, 160);
            for (i = 0; i < phase_cells; i++)
            begin
                c = value_t'($urandom);
                queue_cell(pick_value(c), pick_value(c), pick_value(c), pick_value(c),
                           pick_value(c),
                           {$urandom_range(0, 4) != 0, $urandom_range(0, 2) != 0,
                            $urandom_range(0, 2) != 0, $urandom_range(0, 2) != 0,
                            $urandom_range(0, 2) != 0});
            end
        end

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (cells_accepted < cells_queued || expected_values.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (expected_values.size() != 0)
        begin
            log_failure($sformatf("%0d results never arrived", expected_values.size()));
        end
        $display("%0d cells filtered, %0d results checked, %0d dry-center pass-throughs",
                 cells_accepted, results_checked, dry_passthrough);
        $display("%0d register writes across 1D/2D, wet-dry and 0..7 pass settings; %0d errors",
                 cfg_writes, errors);
        if (errors == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
